[hw/rtl/lavm_pkg.sv]
// shared types, widths and rounding helpers for the look-at view matrix block
package lavm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VEC_W = FRAC_BITS + 34;
  localparam int EW = FRAC_BITS + 3;
  localparam int P_W = 66;
  localparam int ACC_W = 62;
  localparam int LEN_W = 31;
  localparam int Q_W = FRAC_BITS + 1;
  localparam int NUM_W = FRAC_BITS + 31;
  localparam int CNT_W = 5;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] target;
    logic [2:0][31:0] up_hint;
  } item_t;

  typedef struct packed {
    logic degenerate;
    logic [2:0][2:0][EW-1:0] el;
    logic [2:0][31:0] w;
  } rows_t;

  function automatic logic signed [P_W-1:0] round_shift(input logic signed [P_W-1:0] x);
    logic [P_W-1:0] mag;
    mag = x[P_W-1] ? P_W'(-x) : P_W'(x);
    mag = (mag + (P_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[P_W-1] ? $signed(P_W'(-mag)) : $signed(mag);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [P_W-1:0] x);
    logic signed [P_W-1:0] hi;
    logic signed [P_W-1:0] lo;
    hi = $signed({{(P_W-31){1'b0}}, {31{1'b1}}});
    lo = $signed({{(P_W-31){1'b1}}, {31{1'b0}}});
    if (x > hi) begin
      return 32'h7fffffff;
    end else if (x < lo) begin
      return 32'h80000000;
    end
    return x[31:0];
  endfunction

endpackage

[hw/rtl/look_at_view_matrix.sv]
// top level of the look-at view matrix block
// rows follow shift normalization, a 31-step square root and 17-step dividers, run twice;
//   a zero forward vector goes straight to the rows
// the four rows leave on consecutive cycles
// a two-entry queue takes new transactions while the sequencer works; rows are never stalled
// reset is synchronous and clears the queue, the sequencer and the row output
module look_at_view_matrix import lavm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] eye_x,
  input  logic [31:0] eye_y,
  input  logic [31:0] eye_z,
  input  logic [31:0] target_x,
  input  logic [31:0] target_y,
  input  logic [31:0] target_z,
  input  logic [31:0] up_hint_x,
  input  logic [31:0] up_hint_y,
  input  logic [31:0] up_hint_z,
  output logic        strobe,
  output logic [1:0]  row_index,
  output logic [31:0] elem_a,
  output logic [31:0] elem_b,
  output logic [31:0] elem_c,
  output logic [31:0] elem_w,
  output logic        degenerate,
  output logic        last_row
);

  item_t item_in;
  item_t head;
  rows_t rows;
  logic  avail;
  logic  pop;
  logic  load;
  logic  emit_busy;

  always_comb begin
    item_in.eye     = {eye_z, eye_y, eye_x};
    item_in.target  = {target_z, target_y, target_x};
    item_in.up_hint = {up_hint_z, up_hint_y, up_hint_x};
  end

  lavm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item_in (item_in),
    .busy    (busy),
    .pop     (pop),
    .head    (head),
    .avail   (avail)
  );

  lavm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .avail     (avail),
    .pop       (pop),
    .emit_busy (emit_busy),
    .load      (load),
    .rows      (rows)
  );

  lavm_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .rows       (rows),
    .busy       (emit_busy),
    .strobe     (strobe),
    .row_index  (row_index),
    .elem_a     (elem_a),
    .elem_b     (elem_b),
    .elem_c     (elem_c),
    .elem_w     (elem_w),
    .degenerate (degenerate),
    .last_row   (last_row)
  );

  a_rows_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_row |=> strobe && (row_index == $past(row_index) + 2'd1))
    else $error("row burst broken");

  a_const_row: assert property (@(posedge clk) disable iff (rst)
    strobe && last_row |-> elem_a == '0 && elem_b == '0 && elem_c == '0
      && elem_w == (32'(1) << FRAC_BITS))
    else $error("constant row wrong");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && degenerate && !last_row |-> elem_a == '0 && elem_b == '0
      && elem_c == '0 && elem_w == '0)
    else $error("degenerate row not zero");

  a_deg_stable: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_row |=> $stable(degenerate))
    else $error("degenerate flag changed within a matrix");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    load |-> !emit_busy)
    else $error("matrix handed over while rows still going out");

endmodule

[hw/rtl/lavm_front.sv]
// input side: accepts transactions into a short queue ahead of the compute sequencer
module lavm_front import lavm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  item_t item_in,
  output logic  busy,
  input  logic  pop,
  output item_t head,
  output logic  avail
);

  item_t      q [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy  = (count == 2'(QUEUE_DEPTH));
  assign push  = start && !busy;
  assign avail = (count != 2'd0);
  assign head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && avail) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop && avail);
    end
  end

endmodule

[hw/rtl/lavm_core.sv]
// compute sequencer: normalize, cross products and translations on one shared multiplier
module lavm_core import lavm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  item_t head,
  input  logic  avail,
  output logic  pop,
  input  logic  emit_busy,
  output logic  load,
  output rows_t rows
);

  typedef enum logic [3:0] {
    S_IDLE, S_NINIT, S_NCHK, S_NSHIFT, S_SQ, S_SQRT, S_DIV_INIT, S_DIV,
    S_SIDE, S_UP, S_DOT_MUL, S_DOT_ACC, S_DONE
  } state_t;

  state_t state;
  logic [2:0][31:0] eye;
  logic [2:0][31:0] hint;
  logic [2:0][VEC_W-1:0] vec;
  logic [2:0][VEC_W-1:0] m;
  logic [VEC_W-1:0] top;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] rem_n;
  logic [ACC_W-1:0] root;
  logic [ACC_W-1:0] bitv;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] rem;
  logic [Q_W-1:0] nlow;
  logic [Q_W-1:0] quo;
  logic [1:0] idx;
  logic pass;
  logic deg;
  logic [2:0][EW-1:0] fh;
  logic [2:0][EW-1:0] sh;
  logic [2:0][EW-1:0] up;
  logic signed [P_W-1:0] t;
  logic signed [P_W-1:0] p;
  logic [2:0][31:0] w;
  logic [1:0] ri;
  logic [1:0] ei;
  logic [CNT_W-1:0] cnt;

  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic [1:0] ai;
  logic [1:0] bi;
  logic [1:0] sq_i;
  logic [2:0] kk;
  logic [EW-1:0] dot_el;
  logic [ACC_W-1:0] sq_try;
  logic sq_ge;
  logic [ACC_W-1:0] root_nx;
  logic [NUM_W-1:0] num;
  logic [LEN_W:0] r2;
  logic div_ge;
  logic [Q_W-1:0] quo_nx;
  logic [EW-1:0] unit;
  logic signed [P_W-1:0] dot_sum;
  logic [2:0][VEC_W-1:0] mag;
  logic [VEC_W-1:0] mag_max;

  function automatic logic signed [32:0] ext_el(input logic [EW-1:0] x);
    return $signed({{(33-EW){x[EW-1]}}, x});
  endfunction

  // cross product operand order: a1*b2, a2*b1, a2*b0, a0*b2, a0*b1, a1*b0
  always_comb begin
    case (cnt[2:0])
      3'd0: begin ai = 2'd1; bi = 2'd2; end
      3'd1: begin ai = 2'd2; bi = 2'd1; end
      3'd2: begin ai = 2'd2; bi = 2'd0; end
      3'd3: begin ai = 2'd0; bi = 2'd2; end
      3'd4: begin ai = 2'd0; bi = 2'd1; end
      3'd5: begin ai = 2'd1; bi = 2'd0; end
      default: begin ai = 2'd0; bi = 2'd0; end
    endcase
  end

  assign kk   = cnt[2:0] - 3'd1;
  assign sq_i = (cnt[1:0] == 2'd3) ? 2'd0 : cnt[1:0];

  always_comb begin
    case (ri)
      2'd0:    dot_el = sh[ei];
      2'd1:    dot_el = up[ei];
      default: dot_el = EW'(-fh[ei]);
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_SQ: begin
        ma = $signed({1'b0, m[sq_i][31:0]});
        mb = $signed({1'b0, m[sq_i][31:0]});
      end
      S_SIDE: begin
        ma = ext_el(fh[ai]);
        mb = $signed({hint[bi][31], hint[bi]});
      end
      S_UP: begin
        ma = ext_el(sh[ai]);
        mb = ext_el(fh[bi]);
      end
      S_DOT_MUL: begin
        ma = ext_el(dot_el);
        mb = $signed({eye[ei][31], eye[ei]});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec[i][VEC_W-1] ? VEC_W'(-vec[i]) : vec[i];
    end
    mag_max = mag[0];
    if (mag[1] > mag_max) begin
      mag_max = mag[1];
    end
    if (mag[2] > mag_max) begin
      mag_max = mag[2];
    end
  end

  assign sq_try  = root + bitv;
  assign sq_ge   = (rem_n >= sq_try);
  assign root_nx = sq_ge ? ((root >> 1) + bitv) : (root >> 1);

  assign num    = (NUM_W'(m[idx][29:0]) << FRAC_BITS) + NUM_W'(len >> 1);
  assign r2     = {rem, nlow[Q_W-1]};
  assign div_ge = (r2 >= {1'b0, len});
  assign quo_nx = {quo[Q_W-2:0], div_ge};
  assign unit   = vec[idx][VEC_W-1] ? EW'(-EW'(quo_nx)) : EW'(quo_nx);

  assign dot_sum = (ei == 2'd0) ? p : (t + p);

  assign pop  = (state == S_IDLE) && avail;
  assign load = (state == S_DONE) && !emit_busy;

  always_comb begin
    rows.degenerate = deg;
    for (int e = 0; e < 3; e++) begin
      rows.el[0][e] = sh[e];
      rows.el[1][e] = up[e];
      rows.el[2][e] = EW'(-fh[e]);
    end
    rows.w = w;
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
    if (rst) begin
      state <= S_IDLE;
      deg   <= 1'b0;
      pass  <= 1'b0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (avail) begin
            eye  <= head.eye;
            hint <= head.up_hint;
            for (int i = 0; i < 3; i++) begin
              vec[i] <= VEC_W'($signed({head.target[i][31], head.target[i]})
                               - $signed({head.eye[i][31], head.eye[i]}));
            end
            deg   <= 1'b0;
            pass  <= 1'b0;
            state <= S_NINIT;
          end
        end
        S_NINIT: begin
          m     <= mag;
          top   <= mag_max;
          state <= S_NCHK;
        end
        S_NCHK: begin
          if (top == '0) begin
            deg   <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_NSHIFT;
          end
        end
        S_NSHIFT: begin
          if (top >= (VEC_W'(1) << 30)) begin
            for (int i = 0; i < 3; i++) begin
              m[i] <= m[i] >> 1;
            end
            top <= top >> 1;
          end else if (top < (VEC_W'(1) << 29)) begin
            for (int i = 0; i < 3; i++) begin
              m[i] <= m[i] << 1;
            end
            top <= top << 1;
          end else begin
            cnt   <= '0;
            acc   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt != '0) begin
            acc <= acc + p[ACC_W-1:0];
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(3)) begin
            rem_n <= acc + p[ACC_W-1:0];
            root  <= '0;
            bitv  <= ACC_W'(1) << 60;
            cnt   <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            rem_n <= rem_n - sq_try;
          end
          root <= root_nx;
          bitv <= bitv >> 2;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(30)) begin
            len   <= root_nx[LEN_W-1:0];
            idx   <= 2'd0;
            state <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          rem   <= LEN_W'(num[NUM_W-1:Q_W]);
          nlow  <= num[Q_W-1:0];
          quo   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= div_ge ? LEN_W'(r2 - {1'b0, len}) : r2[LEN_W-1:0];
          nlow <= nlow << 1;
          quo  <= quo_nx;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(Q_W - 1)) begin
            if (pass) begin
              sh[idx] <= unit;
            end else begin
              fh[idx] <= unit;
            end
            if (idx == 2'd2) begin
              cnt   <= '0;
              state <= pass ? S_UP : S_SIDE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DIV_INIT;
            end
          end
        end
        S_SIDE: begin
          if (cnt != '0) begin
            if (!kk[0]) begin
              vec[kk[2:1]] <= VEC_W'(p);
            end else begin
              vec[kk[2:1]] <= VEC_W'($signed(vec[kk[2:1]]) - p);
            end
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(6)) begin
            pass  <= 1'b1;
            state <= S_NINIT;
          end
        end
        S_UP: begin
          if (cnt != '0) begin
            if (!kk[0]) begin
              t <= p;
            end else begin
              up[kk[2:1]] <= EW'(round_shift(t - p));
            end
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(6)) begin
            ri    <= 2'd0;
            ei    <= 2'd0;
            state <= S_DOT_MUL;
          end
        end
        S_DOT_MUL: begin
          state <= S_DOT_ACC;
        end
        S_DOT_ACC: begin
          t     <= dot_sum;
          state <= S_DOT_MUL;
          if (ei == 2'd2) begin
            w[ri] <= sat32(-round_shift(dot_sum));
            ei    <= 2'd0;
            if (ri == 2'd2) begin
              state <= S_DONE;
            end else begin
              ri <= ri + 1'b1;
            end
          end else begin
            ei <= ei + 1'b1;
          end
        end
        S_DONE: begin
          if (!emit_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/lavm_emit.sv]
// output side: holds one finished matrix and sends its four rows on consecutive cycles
module lavm_emit import lavm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  rows_t       rows,
  output logic        busy,
  output logic        strobe,
  output logic [1:0]  row_index,
  output logic [31:0] elem_a,
  output logic [31:0] elem_b,
  output logic [31:0] elem_c,
  output logic [31:0] elem_w,
  output logic        degenerate,
  output logic        last_row
);

  rows_t      data;
  logic       active;
  logic [1:0] cnt;

  function automatic logic [31:0] ext32(input logic [EW-1:0] x);
    return {{(32-EW){x[EW-1]}}, x};
  endfunction

  assign busy       = active;
  assign strobe     = active;
  assign row_index  = cnt;
  assign last_row   = (cnt == 2'd3);
  assign degenerate = data.degenerate;

  always_comb begin
    if (cnt == 2'd3) begin
      elem_a = '0;
      elem_b = '0;
      elem_c = '0;
      elem_w = 32'(1) << FRAC_BITS;
    end else if (data.degenerate) begin
      elem_a = '0;
      elem_b = '0;
      elem_c = '0;
      elem_w = '0;
    end else begin
      elem_a = ext32(data.el[cnt][0]);
      elem_b = ext32(data.el[cnt][1]);
      elem_c = ext32(data.el[cnt][2]);
      elem_w = data.w[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= rows;
    end
    if (rst) begin
      active <= 1'b0;
      cnt    <= 2'd0;
    end else if (load) begin
      active <= 1'b1;
      cnt    <= 2'd0;
    end else if (active) begin
      cnt <= cnt + 1'b1;
      if (cnt == 2'd3) begin
        active <= 1'b0;
      end
    end
  end

endmodule

[verif/tb_look_at_view_matrix.sv]
// self-checking testbench for the look-at view matrix block
module tb_look_at_view_matrix;
  import lavm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0] row;
    logic [31:0] a, b, c, w;
    logic deg, last;
  } row_res_t;

  logic clk = 0, rst = 1, start = 0;
  logic busy, strobe, degenerate, last_row;
  logic [31:0] eye_x = 0, eye_y = 0, eye_z = 0;
  logic [31:0] target_x = 0, target_y = 0, target_z = 0;
  logic [31:0] up_hint_x = 0, up_hint_y = 0, up_hint_z = 0;
  logic [1:0] row_index;
  logic [31:0] elem_a, elem_b, elem_c, elem_w;

  item_t pending_q[$];
  row_res_t rows_q[$];
  int errors = 0, sent = 0, rows_seen = 0, degen_seen = 0, gap = 0;
  bit stim_done = 0;

  look_at_view_matrix dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic longint unsigned mag64(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint shr_round(longint x);
    longint unsigned m;
    m = (mag64(x) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned sqrt64(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // returns 1 when the vector is zero
  function automatic bit unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3], top, sum, len, q;
    int rs, ls;
    top = 0; sum = 0; rs = 0; ls = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag64(v[i]);
      if (m[i] > top) top = m[i];
      u[i] = 0;
    end
    if (top == 0) return 1;
    while ((top >> rs) >= (64'd1 << 30)) rs++;
    while ((top << ls) < (64'd1 << 29)) ls++;
    for (int i = 0; i < 3; i++) begin
      m[i] = (m[i] >> rs) << ls;
      sum += m[i] * m[i];
    end
    len = sqrt64(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 0;
  endfunction

  task automatic predict_rows(item_t it);
    longint eye[3], tg[3], hn[3], fwd[3], fh[3], sd[3], sh[3], up[3], dot, t;
    longint mat[3][4];
    bit deg;
    row_res_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(it.eye[i]));
      tg[i] = longint'($signed(it.target[i]));
      hn[i] = longint'($signed(it.up_hint[i]));
      fwd[i] = tg[i] - eye[i];
    end
    deg = unit_vec(fwd, fh);
    if (!deg) begin
      sd[0] = fh[1] * hn[2] - fh[2] * hn[1];
      sd[1] = fh[2] * hn[0] - fh[0] * hn[2];
      sd[2] = fh[0] * hn[1] - fh[1] * hn[0];
      deg = unit_vec(sd, sh);
    end
    for (int j = 0; j < 3; j++) for (int i = 0; i < 4; i++) mat[j][i] = 0;
    if (!deg) begin
      up[0] = shr_round(sh[1] * fh[2] - sh[2] * fh[1]);
      up[1] = shr_round(sh[2] * fh[0] - sh[0] * fh[2]);
      up[2] = shr_round(sh[0] * fh[1] - sh[1] * fh[0]);
      for (int i = 0; i < 3; i++) begin
        mat[0][i] = sh[i];
        mat[1][i] = up[i];
        mat[2][i] = -fh[i];
      end
      for (int j = 0; j < 3; j++) begin
        dot = mat[j][0] * eye[0] + mat[j][1] * eye[1] + mat[j][2] * eye[2];
        t = -shr_round(dot);
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        mat[j][3] = t;
      end
    end
    for (int j = 0; j < 4; j++) begin
      r.row = j[1:0];
      r.deg = deg;
      r.last = (j == 3);
      if (j < 3) begin
        r.a = mat[j][0][31:0]; r.b = mat[j][1][31:0];
        r.c = mat[j][2][31:0]; r.w = mat[j][3][31:0];
      end else begin
        r.a = 0; r.b = 0; r.c = 0; r.w = 32'd1 << FRAC_BITS;
      end
      rows_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_rows(pending_q.pop_front());
        sent++;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      end
      if (!(start && busy)) begin
        if (gap > 0 && !(start && busy)) begin
          gap = gap - 1;
          start <= 0;
        end else if (pending_q.size() > 0) begin
          start <= 1;
          {eye_x, eye_y, eye_z} <= {pending_q[0].eye[0], pending_q[0].eye[1],
                                    pending_q[0].eye[2]};
          {target_x, target_y, target_z} <= {pending_q[0].target[0],
                                    pending_q[0].target[1], pending_q[0].target[2]};
          {up_hint_x, up_hint_y, up_hint_z} <= {pending_q[0].up_hint[0],
                                    pending_q[0].up_hint[1], pending_q[0].up_hint[2]};
        end else begin
          start <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    row_res_t e;
    if (!rst && strobe) begin
      rows_seen++;
      if (rows_q.size() == 0) begin
        report_mismatch("unexpected transaction row", {30'd0, row_index}, 0);
      end else begin
        e = rows_q.pop_front();
        if (degenerate) degen_seen++;
        if (row_index !== e.row) report_mismatch("row_index", row_index, e.row);
        if (elem_a !== e.a) report_mismatch("elem_a", elem_a, e.a);
        if (elem_b !== e.b) report_mismatch("elem_b", elem_b, e.b);
        if (elem_c !== e.c) report_mismatch("elem_c", elem_c, e.c);
        if (elem_w !== e.w) report_mismatch("elem_w", elem_w, e.w);
        if (degenerate !== e.deg) report_mismatch("degenerate", degenerate, e.deg);
        if (last_row !== e.last) report_mismatch("last_row", last_row, e.last);
      end
    end
  end

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 2) == 0 ? 32'h80000000 : 32'h7fffffff;
      2: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      3: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
    endcase
  endfunction

  function automatic item_t mk(logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    item_t it;
    it.eye[0] = ex; it.eye[1] = ey; it.eye[2] = ez;
    it.target[0] = tx; it.target[1] = ty; it.target[2] = tz;
    it.up_hint[0] = ux; it.up_hint[1] = uy; it.up_hint[2] = uz;
    return it;
  endfunction

  initial begin
    item_t it;
    logic [31:0] one, mx, mn;
    one = 32'd1 << FRAC_BITS; mx = 32'h7fffffff; mn = 32'h80000000;
    // directed: plain camera, degenerate forward, parallel up, zero up, extremes
    pending_q.push_back(mk(0, 0, 5 * one, 0, 0, 0, 0, one, 0));
    pending_q.push_back(mk(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, 0));
    pending_q.push_back(mk(0, 0, 0, 0, 0, one, 0, 0, one));
    pending_q.push_back(mk(0, 0, 0, one, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(mn, mn, mn, mx, mx, mx, mx, mn, 1));
    pending_q.push_back(mk(mx, mx, mx, mn, mn, mn, mn, mx, mx));
    pending_q.push_back(mk(mx, mn, mx, mn, mx, mn, one, 0, 0));
    pending_q.push_back(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_q.push_back(mk(mx, mx, mx, mn, 0, 0, 0, mx, 0));
    pending_q.push_back(mk(32'hffffffff, 1, 0, 0, 0, 0, 32'hffffffff, 0, mn));
    pending_q.push_back(mk(mn, 0, mx, 0, mn, 0, 0, 0, mx));
    pending_q.push_back(mk(0, 0, 0, mn, mn, mn, mn, mn, mn));
    for (int n = 0; n < 100; n++) begin
      it = mk(rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_val(),
              rnd_val(), rnd_val(), rnd_val());
      if ($urandom_range(0, 15) == 0) it.target = it.eye;
      if ($urandom_range(0, 15) == 0) it.up_hint = it.target;
      pending_q.push_back(it);
    end
    repeat (6) @(posedge clk);
    rst <= 0;
    wait (pending_q.size() == 0 && !start);
    wait (rows_q.size() == 0);
    repeat (300) @(posedge clk);
    $display("sent %0d transactions, checked %0d rows (%0d degenerate)",
             sent, rows_seen, degen_seen);
    if (errors == 0 && rows_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule
